@@ hw/rtl/scw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scw_pkg: shared widths and helpers for the segment crossing block.
// Holds the fixed-point widths of every pipeline stage and the quotient
// unit, and small sign and magnitude helpers.
// ----------------------------------------------------------------------------
package scw_pkg;

  // Fraction bits of the Q-format coordinates.
  localparam int FRAC_BITS = 16;

  // Coordinate width and the width of a difference of two coordinates.
  localparam int CW = 32;
  localparam int VW = CW + 1;

  // Product of two differences, and a sum of two such products.
  localparam int PW = 2 * VW;
  localparam int SW = PW + 1;

  // Split of a cross product magnitude into a low and a high part.
  localparam int LOW  = VW + 1;
  localparam int HIW  = SW - LOW;
  localparam int LOPW = VW + LOW;
  localparam int HIPW = VW + HIW;

  // Quotient unit: dividend, divisor and quotient widths.
  localparam int NW = VW + SW + 1;
  localparam int DW = SW + 1;
  localparam int QW = VW + 2;

  // Width of the final sum before saturation.
  localparam int RW = QW + 3;

  // One unit of the cross product squared scale, used for the snap test.
  localparam logic signed [SW-1:0] SNAP = SW'(1) <<< (2 * FRAC_BITS);

  // Sign extension of a coordinate to a difference width.
  function automatic logic signed [VW-1:0] ext_coord(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  // Sign extension of a product to a sum width.
  function automatic logic signed [SW-1:0] ext_prod(input logic signed [PW-1:0] v);
    return {v[PW-1], v};
  endfunction

  // Magnitude of a cross product; the most negative value maps correctly.
  function automatic logic [SW-1:0] mag_sum(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  // Magnitude of a difference.
  function automatic logic [VW-1:0] mag_diff(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scw_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scw_div: pipelined restoring divider.
// Produces one quotient bit per stage, QW stages deep, and accepts a new
// dividend and divisor in every enabled cycle. The upper dividend bits must
// be below the divisor, so the quotient fits QW bits.
// ----------------------------------------------------------------------------
module scw_div (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [scw_pkg::NW-1:0] num,
  input  wire logic [scw_pkg::DW-1:0] den,
  output logic      [scw_pkg::QW-1:0] quo
);

  localparam int NW = scw_pkg::NW;
  localparam int DW = scw_pkg::DW;
  localparam int QW = scw_pkg::QW;

  // Stage registers: dividend, divisor, partial remainder, partial quotient.
  logic [NW-1:0] n_q [QW];
  logic [DW-1:0] d_q [QW];
  logic [DW-1:0] r_q [QW];
  logic [QW-1:0] q_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [DW-1:0] d_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign n_in = num;
      assign d_in = den;
      assign r_in = DW'(num[NW-1:QW]);
      assign q_in = '0;
    end else begin : g_rest
      assign n_in = n_q[j-1];
      assign d_in = d_q[j-1];
      assign r_in = r_q[j-1];
      assign q_in = q_q[j-1];
    end

    // One restoring step: bring down the next dividend bit and subtract.
    assign trial = {r_in, n_in[QW-1-j]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[j] <= n_in;
        d_q[j] <= d_in;
        r_q[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_q[j] <= q_in | (QW'(ge) << (QW-1-j));
      end
    end
  end

  assign quo = q_q[QW-1];

endmodule

`default_nettype wire

@@ hw/rtl/segment_crossing_wall_slide.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segment_crossing_wall_slide: move versus wall crossing test with slide.
// Tests whether a move from an old to a new point crosses a wall segment
// from its front to its back side, and in slide mode returns the corrected
// position on the wall.
// ----------------------------------------------------------------------------
// The block takes one query per cycle while s_axis_tready is high and returns one
// result per query in order. A result passes six arithmetic stages, the 35-stage
// quotient units that form the slide offsets one bit per stage, a summing stage and
// the output register.
// A skid entry behind the output register takes the next result that reaches
// the end of the pipeline while the output stalls; s_axis_tready then drops
// until that entry drains. With a full pipeline this means one more input
// transfer after the stall begins.
// Input tdata carries new_x, new_z, old_x, old_z, seg_start_x, seg_start_z,
// seg_end_x, seg_end_z from the lowest bits up; tuser carries slide_mode then
// reversed. Output tdata carries out_x then out_z; tuser carries hit.
module segment_crossing_wall_slide (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // new_x, new_z, old_x, old_z, seg_start_x, seg_start_z, seg_end_x, seg_end_z
  input  wire logic [255:0] s_axis_tdata,
  // slide_mode, reversed
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_x, out_z
  output logic [63:0]       m_axis_tdata,
  // hit
  output logic [0:0]        m_axis_tuser
);

  localparam int CW   = scw_pkg::CW;
  localparam int VW   = scw_pkg::VW;
  localparam int PW   = scw_pkg::PW;
  localparam int SW   = scw_pkg::SW;
  localparam int LOW  = scw_pkg::LOW;
  localparam int LOPW = scw_pkg::LOPW;
  localparam int HIPW = scw_pkg::HIPW;
  localparam int NW   = scw_pkg::NW;
  localparam int DW   = scw_pkg::DW;
  localparam int QW   = scw_pkg::QW;
  localparam int RW   = scw_pkg::RW;

  localparam logic signed [RW-1:0] SAT_MAX = (RW'(1) <<< (CW-1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_MIN = -(RW'(1) <<< (CW-1));

  typedef struct packed {
    logic            hit;
    logic            slide;
    logic            s_xn;
    logic            s_zn;
    logic            s_xd;
    logic            s_zd;
    logic [CW-1:0]   bx;
    logic [CW-1:0]   bz;
    logic [CW-1:0]   nx;
    logic [CW-1:0]   nz;
  } meta_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] ox;
    logic [CW-1:0] oz;
  } res_t;

  // Pipeline advances whenever the output buffer has room.
  logic en;
  logic skid_valid;
  assign en = !skid_valid;
  assign s_axis_tready = en;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Input field unpacking.
  logic signed [CW-1:0] in_nx, in_nz, in_ox, in_oz, in_sx, in_sz, in_ex, in_ez;
  assign in_nx = s_axis_tdata[31:0];
  assign in_nz = s_axis_tdata[63:32];
  assign in_ox = s_axis_tdata[95:64];
  assign in_oz = s_axis_tdata[127:96];
  assign in_sx = s_axis_tdata[159:128];
  assign in_sz = s_axis_tdata[191:160];
  assign in_ex = s_axis_tdata[223:192];
  assign in_ez = s_axis_tdata[255:224];

  // Stage 0: base point, wall vector and the three move vectors.
  logic                 v0;
  logic signed [CW-1:0] s0_bx, s0_bz, s0_nx, s0_nz;
  logic signed [VW-1:0] s0_lx, s0_lz, s0_px, s0_pz, s0_qx, s0_qz, s0_mx, s0_mz;
  logic                 s0_slide;
  logic signed [CW-1:0] base_x, base_z;
  logic signed [VW-1:0] wall_x, wall_z;

  always_comb begin
    base_x = s_axis_tuser[1] ? in_ex : in_sx;
    base_z = s_axis_tuser[1] ? in_ez : in_sz;
    wall_x = s_axis_tuser[1] ? scw_pkg::ext_coord(in_sx) - scw_pkg::ext_coord(in_ex)
                             : scw_pkg::ext_coord(in_ex) - scw_pkg::ext_coord(in_sx);
    wall_z = s_axis_tuser[1] ? scw_pkg::ext_coord(in_sz) - scw_pkg::ext_coord(in_ez)
                             : scw_pkg::ext_coord(in_ez) - scw_pkg::ext_coord(in_sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_bx    <= base_x;
      s0_bz    <= base_z;
      s0_nx    <= in_nx;
      s0_nz    <= in_nz;
      s0_lx    <= wall_x;
      s0_lz    <= wall_z;
      s0_px    <= scw_pkg::ext_coord(in_nx) - scw_pkg::ext_coord(base_x);
      s0_pz    <= scw_pkg::ext_coord(in_nz) - scw_pkg::ext_coord(base_z);
      s0_qx    <= scw_pkg::ext_coord(in_ox) - scw_pkg::ext_coord(base_x);
      s0_qz    <= scw_pkg::ext_coord(in_oz) - scw_pkg::ext_coord(base_z);
      s0_mx    <= scw_pkg::ext_coord(in_nx) - scw_pkg::ext_coord(in_ox);
      s0_mz    <= scw_pkg::ext_coord(in_nz) - scw_pkg::ext_coord(in_oz);
      s0_slide <= s_axis_tuser[0];
    end
  end

  // Stage 1: all twelve cross and dot product terms.
  logic                 v1;
  logic signed [CW-1:0] s1_bx, s1_bz, s1_nx, s1_nz;
  logic signed [VW-1:0] s1_lx, s1_lz;
  logic                 s1_slide;
  logic signed [PW-1:0] p_lzpx, p_lxpz, p_lzqx, p_lxqz, p_pzmx, p_pxmz;
  logic signed [PW-1:0] p_lzmx, p_lxmz, p_lxmx, p_lzmz, p_lxlx, p_lzlz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bx    <= s0_bx;
      s1_bz    <= s0_bz;
      s1_nx    <= s0_nx;
      s1_nz    <= s0_nz;
      s1_lx    <= s0_lx;
      s1_lz    <= s0_lz;
      s1_slide <= s0_slide;
      p_lzpx   <= s0_lz * s0_px;
      p_lxpz   <= s0_lx * s0_pz;
      p_lzqx   <= s0_lz * s0_qx;
      p_lxqz   <= s0_lx * s0_qz;
      p_pzmx   <= s0_pz * s0_mx;
      p_pxmz   <= s0_px * s0_mz;
      p_lzmx   <= s0_lz * s0_mx;
      p_lxmz   <= s0_lx * s0_mz;
      p_lxmx   <= s0_lx * s0_mx;
      p_lzmz   <= s0_lz * s0_mz;
      p_lxlx   <= s0_lx * s0_lx;
      p_lzlz   <= s0_lz * s0_lz;
    end
  end

  // Stage 2: cross products, dot product and squared wall length.
  logic                 v2;
  logic signed [CW-1:0] s2_bx, s2_bz, s2_nx, s2_nz;
  logic signed [VW-1:0] s2_lx, s2_lz;
  logic                 s2_slide;
  logic signed [SW-1:0] s2_cn, s2_co, s2_num, s2_den, s2_dot, s2_len2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bx    <= s1_bx;
      s2_bz    <= s1_bz;
      s2_nx    <= s1_nx;
      s2_nz    <= s1_nz;
      s2_lx    <= s1_lx;
      s2_lz    <= s1_lz;
      s2_slide <= s1_slide;
      s2_cn    <= scw_pkg::ext_prod(p_lzpx) - scw_pkg::ext_prod(p_lxpz);
      s2_co    <= scw_pkg::ext_prod(p_lzqx) - scw_pkg::ext_prod(p_lxqz);
      s2_num   <= scw_pkg::ext_prod(p_pzmx) - scw_pkg::ext_prod(p_pxmz);
      s2_den   <= scw_pkg::ext_prod(p_lzmx) - scw_pkg::ext_prod(p_lxmz);
      s2_dot   <= scw_pkg::ext_prod(p_lxmx) + scw_pkg::ext_prod(p_lzmz);
      s2_len2  <= scw_pkg::ext_prod(p_lxlx) + scw_pkg::ext_prod(p_lzlz);
    end
  end

  // Stage 3: side tests, signs and magnitudes.
  logic                 v3;
  logic signed [CW-1:0] s3_bx, s3_bz, s3_nx, s3_nz;
  logic                 s3_slide;
  logic                 s3_new_back, s3_old_front;
  logic                 s3_num_neg, s3_den_neg, s3_dot_neg, s3_lx_neg, s3_lz_neg;
  logic [SW-1:0]        s3_nmag, s3_dmag, s3_tmag, s3_len2;
  logic [VW-1:0]        s3_lxm, s3_lzm;
  logic signed [SW-1:0] old_shift;

  // The old point counts as on the wall when its cross product is above -1.0.
  assign old_shift = s2_co + scw_pkg::SNAP;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_bx        <= s2_bx;
      s3_bz        <= s2_bz;
      s3_nx        <= s2_nx;
      s3_nz        <= s2_nz;
      s3_slide     <= s2_slide;
      s3_new_back  <= s2_cn[SW-1];
      s3_old_front <= !old_shift[SW-1] && (old_shift != '0);
      s3_num_neg   <= s2_num[SW-1];
      s3_den_neg   <= s2_den[SW-1];
      s3_dot_neg   <= s2_dot[SW-1];
      s3_lx_neg    <= s2_lx[VW-1];
      s3_lz_neg    <= s2_lz[VW-1];
      s3_nmag      <= scw_pkg::mag_sum(s2_num);
      s3_dmag      <= scw_pkg::mag_sum(s2_den);
      s3_tmag      <= scw_pkg::mag_sum(s2_dot);
      s3_len2      <= s2_len2;
      s3_lxm       <= scw_pkg::mag_diff(s2_lx);
      s3_lzm       <= scw_pkg::mag_diff(s2_lz);
    end
  end

  // Stage 4: hit decision and partial products of the slide dividends.
  logic          v4;
  meta_t         s4_meta;
  logic [SW-1:0] s4_dmag, s4_len2;
  logic [LOPW-1:0] pp_xn_lo, pp_zn_lo, pp_xd_lo, pp_zd_lo;
  logic [HIPW-1:0] pp_xn_hi, pp_zn_hi, pp_xd_hi, pp_zd_hi;
  logic          rate_ok;

  // The crossing ratio lies in [0,1] when num and den agree in sign and
  // |num| does not exceed |den|.
  assign rate_ok = (s3_dmag != '0) && ((s3_nmag == '0) || (s3_num_neg == s3_den_neg))
                   && (s3_dmag >= s3_nmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_meta.hit   <= s3_new_back && s3_old_front && rate_ok;
      s4_meta.slide <= s3_slide;
      s4_meta.s_xn  <= s3_lx_neg ^ s3_num_neg ^ s3_den_neg;
      s4_meta.s_zn  <= s3_lz_neg ^ s3_num_neg ^ s3_den_neg;
      s4_meta.s_xd  <= s3_lx_neg ^ s3_dot_neg;
      s4_meta.s_zd  <= s3_lz_neg ^ s3_dot_neg;
      s4_meta.bx    <= s3_bx;
      s4_meta.bz    <= s3_bz;
      s4_meta.nx    <= s3_nx;
      s4_meta.nz    <= s3_nz;
      s4_dmag       <= s3_dmag;
      s4_len2       <= s3_len2;
      pp_xn_lo      <= s3_lxm * s3_nmag[LOW-1:0];
      pp_xn_hi      <= s3_lxm * s3_nmag[SW-1:LOW];
      pp_zn_lo      <= s3_lzm * s3_nmag[LOW-1:0];
      pp_zn_hi      <= s3_lzm * s3_nmag[SW-1:LOW];
      pp_xd_lo      <= s3_lxm * s3_tmag[LOW-1:0];
      pp_xd_hi      <= s3_lxm * s3_tmag[SW-1:LOW];
      pp_zd_lo      <= s3_lzm * s3_tmag[LOW-1:0];
      pp_zd_hi      <= s3_lzm * s3_tmag[SW-1:LOW];
    end
  end

  // Stage 5: dividends and divisors for round-to-nearest division.
  logic          v5;
  meta_t         s5_meta;
  logic [NW-1:0] dv_xn, dv_zn, dv_xd, dv_zd;
  logic [DW-1:0] dr_den, dr_len;

  function automatic logic [NW-1:0] rdividend(input logic [LOPW-1:0] lo,
                                              input logic [HIPW-1:0] hi,
                                              input logic [SW-1:0]   d);
    logic [NW-1:0] prod;
    prod = NW'(lo) + (NW'(hi) << LOW);
    return (prod << 1) + NW'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_meta <= s4_meta;
      dv_xn   <= rdividend(pp_xn_lo, pp_xn_hi, s4_dmag);
      dv_zn   <= rdividend(pp_zn_lo, pp_zn_hi, s4_dmag);
      dv_xd   <= rdividend(pp_xd_lo, pp_xd_hi, s4_len2);
      dv_zd   <= rdividend(pp_zd_lo, pp_zd_hi, s4_len2);
      dr_den  <= {s4_dmag, 1'b0};
      dr_len  <= {s4_len2, 1'b0};
    end
  end

  // Quotient units for the crossing offset and the wall projection.
  logic [QW-1:0] q_xn, q_zn, q_xd, q_zd;

  scw_div u_div_xn (.clk(clk), .en(en), .num(dv_xn), .den(dr_den), .quo(q_xn));
  scw_div u_div_zn (.clk(clk), .en(en), .num(dv_zn), .den(dr_den), .quo(q_zn));
  scw_div u_div_xd (.clk(clk), .en(en), .num(dv_xd), .den(dr_len), .quo(q_xd));
  scw_div u_div_zd (.clk(clk), .en(en), .num(dv_zd), .den(dr_len), .quo(q_zd));

  // Side line that keeps the item's flags beside the quotient units.
  logic  vq     [QW];
  meta_t meta_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= (k == 0) ? v5 : vq[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_q[k] <= (k == 0) ? s5_meta : meta_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Final stage: signed offsets, sum and saturation.
  logic             f_valid;
  res_t             f_data;
  meta_t            ml;
  logic signed [RW-1:0] t_xn, t_zn, t_xd, t_zd, sum_x, sum_z, sat_x, sat_z;

  assign ml = meta_q[QW-1];

  always_comb begin
    t_xn  = ml.s_xn ? -RW'(q_xn) : RW'(q_xn);
    t_zn  = ml.s_zn ? -RW'(q_zn) : RW'(q_zn);
    t_xd  = ml.s_xd ? -RW'(q_xd) : RW'(q_xd);
    t_zd  = ml.s_zd ? -RW'(q_zd) : RW'(q_zd);
    sum_x = RW'($signed(ml.bx)) + t_xn + t_xd;
    sum_z = RW'($signed(ml.bz)) + t_zn + t_zd;
    sat_x = (sum_x > SAT_MAX) ? SAT_MAX : ((sum_x < SAT_MIN) ? SAT_MIN : sum_x);
    sat_z = (sum_z > SAT_MAX) ? SAT_MAX : ((sum_z < SAT_MIN) ? SAT_MIN : sum_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= vq[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_data.hit <= ml.hit;
      f_data.ox  <= (ml.hit && ml.slide) ? sat_x[CW-1:0] : ml.nx;
      f_data.oz  <= (ml.hit && ml.slide) ? sat_z[CW-1:0] : ml.nz;
    end
  end

  // Output register with a skid entry that takes one result during a stall.
  res_t out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        out_data      <= skid_data;
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else if (f_valid) begin
        out_data      <= f_data;
        m_axis_tvalid <= 1'b1;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end else if (en && f_valid) begin
      skid_data  <= f_data;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tdata = {out_data.oz, out_data.ox};
  assign m_axis_tuser = out_data.hit;

  // The skid entry only fills behind a stalled output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry holds a result while the output is empty");

  // A parallel or zero move never produces a hit.
  a_zero_den_no_hit: assert property (@(posedge clk) disable iff (rst)
    (en && s3_dmag == '0) |=> !s4_meta.hit)
    else $error("hit flagged with a zero denominator");

  // Without a hit the new point passes through unchanged.
  a_miss_passes: assert property (@(posedge clk) disable iff (rst)
    (en && vq[QW-1] && !ml.hit) |=> (f_data.ox == $past(ml.nx)))
    else $error("new x altered on a miss");

endmodule

`default_nettype wire
